>>> hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands, clocked on clk and held off while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication: when ante holds, cons must hold (cons may be a sequence).
`define ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/lcme_pkg.sv
// ----------------------------------------------------------------------------
// lcme_pkg
// Shared types and constants of the LED channel modify engine.
// ----------------------------------------------------------------------------
`default_nettype none

package lcme_pkg;

  localparam int DATA_W   = 32;
  localparam int CH_W     = 10;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 2;
  localparam int REG_COUNT = 4;

  // defaults of the top level parameters
  localparam int DEF_CHANNELS_PER_BANK = 144;
  localparam int DEF_BANK_COUNT        = 4;

  // element / data width codes
  localparam logic [1:0] WCODE_8    = 2'd0;
  localparam logic [1:0] WCODE_16   = 2'd1;
  localparam logic [1:0] WCODE_32   = 2'd2;
  localparam logic [1:0] WCODE_RSVD = 2'd3;

  typedef enum logic [2:0] {
    CMD_SET     = 3'd0,
    CMD_ADD     = 3'd1,
    CMD_SUB     = 3'd2,
    CMD_SHL     = 3'd3,
    CMD_SHR     = 3'd4,
    CMD_ADD_SAT = 3'd5,
    CMD_SUB_SAT = 3'd6
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK          = 2'd0,
    ST_BAD_CHANNEL = 2'd1,
    ST_TOO_WIDE    = 2'd2,
    ST_BAD_OP      = 2'd3
  } status_t;

  // operands of the modify stage
  typedef struct packed {
    cmd_t              cmd;
    logic [DATA_W-1:0] operand;
    logic [1:0]        data_width;
    logic [1:0]        bank_width;
    logic [DATA_W-1:0] stored;
    logic              ch_ok;
  } alu_in_t;

  // outcome of the modify stage
  typedef struct packed {
    logic [DATA_W-1:0] new_value;
    status_t           status;
    logic              wr_en;
  } alu_out_t;

endpackage

`default_nettype wire

>>> hdl/lcme_ram.sv
// ----------------------------------------------------------------------------
// lcme_ram
// Channel store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module lcme_ram #(
  parameter int DEPTH  = 576,
  parameter int ADDR_W = 10
) (
  input  wire logic                      clk,
  input  wire logic                      we,
  input  wire logic [ADDR_W-1:0]         waddr,
  input  wire logic [lcme_pkg::DATA_W-1:0] wdata,
  input  wire logic [ADDR_W-1:0]         raddr,
  output logic      [lcme_pkg::DATA_W-1:0] rdata
);
  import lcme_pkg::*;

  logic [DATA_W-1:0] mem [DEPTH];

  // read returns the old word on a same-address write
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

>>> hdl/lcme_alu.sv
// ----------------------------------------------------------------------------
// lcme_alu
// Checks one item and applies its operation at the bank's element width.
// ----------------------------------------------------------------------------
`default_nettype none

module lcme_alu (
  input  wire lcme_pkg::alu_in_t  alu_in,
  output lcme_pkg::alu_out_t      alu_out
);
  import lcme_pkg::*;

  function automatic logic [DATA_W-1:0] width_mask(logic [1:0] code);
    logic [DATA_W-1:0] m;
    case (code)
      WCODE_8:  m = 32'h0000_00FF;
      WCODE_16: m = 32'h0000_FFFF;
      default:  m = 32'hFFFF_FFFF;
    endcase
    return m;
  endfunction

  function automatic logic [5:0] width_bits(logic [1:0] code);
    logic [5:0] b;
    case (code)
      WCODE_8:  b = 6'd8;
      WCODE_16: b = 6'd16;
      default:  b = 6'd32;
    endcase
    return b;
  endfunction

  logic [DATA_W-1:0] mask;
  logic [DATA_W-1:0] old;
  logic [DATA_W-1:0] d;
  logic              shift_big;
  logic [DATA_W:0]   sum;
  logic [DATA_W-1:0] diff;
  logic              too_wide;

  assign mask      = width_mask(alu_in.bank_width);
  assign old       = alu_in.stored & mask;
  assign d         = alu_in.operand & width_mask(alu_in.data_width);
  assign shift_big = d >= {26'd0, width_bits(alu_in.bank_width)};
  assign sum       = {1'b0, old} + {1'b0, d};
  assign diff      = old - d;
  assign too_wide  = (alu_in.data_width == WCODE_RSVD) || (alu_in.bank_width == WCODE_RSVD)
                     || (alu_in.data_width > alu_in.bank_width);

  // priority: bad channel, bad operation, width
  always_comb begin
    alu_out.new_value = old;
    alu_out.status    = ST_OK;
    alu_out.wr_en     = 1'b0;
    if (!alu_in.ch_ok) begin
      alu_out.new_value = '0;
      alu_out.status    = ST_BAD_CHANNEL;
    end else if (alu_in.cmd inside {CMD_SET, CMD_ADD, CMD_SUB, CMD_SHL, CMD_SHR,
                                    CMD_ADD_SAT, CMD_SUB_SAT}) begin
      if (too_wide) begin
        alu_out.status = ST_TOO_WIDE;
      end else begin
        alu_out.wr_en = 1'b1;
        case (alu_in.cmd)
          CMD_SET:     alu_out.new_value = d;
          CMD_ADD:     alu_out.new_value = sum[DATA_W-1:0] & mask;
          CMD_SUB:     alu_out.new_value = diff & mask;
          CMD_SHL:     alu_out.new_value = shift_big ? '0 : ((old << d[4:0]) & mask);
          CMD_SHR:     alu_out.new_value = shift_big ? '0 : (old >> d[4:0]);
          CMD_ADD_SAT: alu_out.new_value = (sum > {1'b0, mask}) ? mask : sum[DATA_W-1:0];
          default:     alu_out.new_value = (d > old) ? '0 : diff;
        endcase
      end
    end else begin
      alu_out.status = ST_BAD_OP;
    end
  end

endmodule

`default_nettype wire

>>> hdl/led_channel_modify_engine.sv
// ----------------------------------------------------------------------------
// led_channel_modify_engine
// Read-modify-write engine over a banked store of LED channel intensities.
//
//  channel  | handshake         | payload
//  ---------+-------------------+-----------------------------------------------
//  in       | start / busy      | in_cmd, in_channel, in_operand,
//           |                   | in_data_width, in_last_of_pixel
//  out      | out_valid strobe  | out_new_value, out_status, out_last_out
//  cfg      | cfg_we            | cfg_index, cfg_data
//
// One item per cycle while busy is low; the result strobes from the result register,
// behind the read stage registers. The store is read as an item is accepted; the
// item is modified and written back from the read stage, and a one-entry write
// forwarding register covers back-to-back items on the same channel. After reset a
// clearing pass zeroes the store, one word a cycle (576 words by default); busy is
// high meanwhile. Configuration writes are taken at any time. Results cannot be held off.
// ----------------------------------------------------------------------------
`default_nettype none

module led_channel_modify_engine #(
  parameter int CHANNELS_PER_BANK = lcme_pkg::DEF_CHANNELS_PER_BANK,
  parameter int BANK_COUNT        = lcme_pkg::DEF_BANK_COUNT
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  // input items
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [2:0]                    in_cmd,
  input  wire logic [lcme_pkg::CH_W-1:0]     in_channel,
  input  wire logic [lcme_pkg::DATA_W-1:0]   in_operand,
  input  wire logic [1:0]                    in_data_width,
  input  wire logic                          in_last_of_pixel,
  // results
  output logic                               out_valid,
  output logic [lcme_pkg::DATA_W-1:0]        out_new_value,
  output logic [1:0]                         out_status,
  output logic                               out_last_out,
  // configuration
  input  wire logic                          cfg_we,
  input  wire logic [lcme_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [lcme_pkg::CFG_DAT_W-1:0] cfg_data
);
  import lcme_pkg::*;

  localparam int TOTAL  = CHANNELS_PER_BANK * BANK_COUNT;
  localparam int DEPTH  = (TOTAL > (1 << CH_W)) ? (1 << CH_W) : TOTAL;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CMP_W  = 13;

  // bank width registers
  logic [1:0] bank_width_r [REG_COUNT];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < REG_COUNT; i++) bank_width_r[i] <= WCODE_8;
    end else if (cfg_we) begin
      bank_width_r[cfg_index] <= cfg_data;
    end
  end

  // clearing pass after reset
  logic              clearing_r, clearing_nxt;
  logic [ADDR_W-1:0] clr_cnt_r, clr_cnt_nxt;

  always_comb begin
    clearing_nxt = clearing_r;
    clr_cnt_nxt  = clr_cnt_r;
    if (clearing_r) begin
      clr_cnt_nxt = clr_cnt_r + 1'b1;
      if (clr_cnt_r == ADDR_W'(DEPTH - 1)) clearing_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clearing_r <= 1'b1;
      clr_cnt_r  <= '0;
    end else begin
      clearing_r <= clearing_nxt;
      clr_cnt_r  <= clr_cnt_nxt;
    end
  end

  assign busy = clearing_r;

  logic accept;
  assign accept = start && !busy;

  // read stage registers
  logic              s1_valid_r;
  logic [2:0]        s1_cmd_r;
  logic [CH_W-1:0]   s1_ch_r;
  logic [DATA_W-1:0] s1_operand_r;
  logic [1:0]        s1_dw_r;
  logic              s1_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) s1_valid_r <= 1'b0;
    else        s1_valid_r <= accept;
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_cmd_r     <= in_cmd;
      s1_ch_r      <= in_channel;
      s1_operand_r <= in_operand;
      s1_dw_r      <= in_data_width;
      s1_last_r    <= in_last_of_pixel;
    end
  end

  // store
  alu_in_t           alu_in;
  alu_out_t          alu_out;
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [DATA_W-1:0] ram_wdata;
  logic [DATA_W-1:0] ram_rdata;
  logic [ADDR_W-1:0] s1_addr;
  logic              item_wr;

  assign s1_addr   = s1_ch_r[ADDR_W-1:0];
  assign item_wr   = s1_valid_r && alu_out.wr_en;
  assign ram_we    = clearing_r || item_wr;
  assign ram_waddr = clearing_r ? clr_cnt_r : s1_addr;
  assign ram_wdata = clearing_r ? '0 : alu_out.new_value;

  lcme_ram #(
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (in_channel[ADDR_W-1:0]),
    .rdata (ram_rdata)
  );

  // forwarding of the previous cycle's write
  logic              fwd_valid_r;
  logic [ADDR_W-1:0] fwd_addr_r;
  logic [DATA_W-1:0] fwd_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) fwd_valid_r <= 1'b0;
    else        fwd_valid_r <= item_wr;
  end

  always_ff @(posedge clk) begin
    fwd_addr_r <= s1_addr;
    fwd_data_r <= alu_out.new_value;
  end

  // bank lookup by threshold compares
  logic [1:0] bank;
  logic       ch_ok;

  always_comb begin : bank_sel
    bank = '0;
    for (int k = 1; k < REG_COUNT; k++) begin
      if (k < BANK_COUNT && CMP_W'(s1_ch_r) >= CMP_W'(k * CHANNELS_PER_BANK)) bank = 2'(k);
    end
  end

  assign ch_ok = CMP_W'(s1_ch_r) < CMP_W'(TOTAL);

  always_comb begin
    alu_in.cmd        = cmd_t'(s1_cmd_r);
    alu_in.operand    = s1_operand_r;
    alu_in.data_width = s1_dw_r;
    alu_in.bank_width = bank_width_r[bank];
    alu_in.stored     = (fwd_valid_r && fwd_addr_r == s1_addr) ? fwd_data_r : ram_rdata;
    alu_in.ch_ok      = ch_ok;
  end

  lcme_alu u_alu (
    .alu_in  (alu_in),
    .alu_out (alu_out)
  );

  // result register
  logic              out_valid_r;
  logic [DATA_W-1:0] out_value_r;
  status_t           out_status_r;
  logic              out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else        out_valid_r <= s1_valid_r;
  end

  always_ff @(posedge clk) begin
    if (s1_valid_r) begin
      out_value_r  <= alu_out.new_value;
      out_status_r <= alu_out.status;
      out_last_r   <= s1_last_r;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_new_value = out_value_r;
  assign out_status    = out_status_r;
  assign out_last_out  = out_last_r;

  // checks
  `include "assert_macros.svh"

  `ASSERT_IMPL(a_result_latency, start && !busy, ##2 out_valid, "accepted word gave no result")
  `ASSERT_IMPL(a_idle_while_clearing, clearing_r, !s1_valid_r, "item in flight during clear")
  `ASSERT_IMPL(a_write_only_ok, item_wr, alu_out.status == ST_OK, "store written on error")
  `ASSERT_NEXT(a_bad_ch_zero, s1_valid_r && !ch_ok,
               out_status == ST_BAD_CHANNEL && out_new_value == '0, "bad channel result")

endmodule

`default_nettype wire

>>> dv/led_channel_modify_engine_test.sv
// ----------------------------------------------------------------------------
// led_channel_modify_engine_test
// Self-checking bench for the LED channel modify engine. Words go in through
// the start/busy port; a local model of the banked store predicts each result.
// The monitor checks every strobed result in order. The bench cycles the bank
// width registers through all codes, the reserved one included, and idles the
// sender at several rates.
// ----------------------------------------------------------------------------
`default_nettype none

module led_channel_modify_engine_test;
  timeunit 1ns;
  timeprecision 1ps;

  import lcme_pkg::*;

  localparam int CH_PER_BANK   = DEF_CHANNELS_PER_BANK;
  localparam int TOTAL_CH      = DEF_CHANNELS_PER_BANK * DEF_BANK_COUNT;
  localparam int RUN_LIMIT_NS  = 2_400_000;
  localparam int PHASE_WORDS   = 300;
  localparam int DRAIN_CHUNK   = 50;

  // register indexes
  localparam int REG_BANK0_WIDTH = 0;
  localparam int REG_BANK3_WIDTH = 3;

  // opcode the engine must reject
  localparam logic [2:0] CMD_BAD = 3'd7;

  typedef struct {
    logic [2:0]        cmd;
    logic [CH_W-1:0]   channel;
    logic [DATA_W-1:0] operand;
    logic [1:0]        dwidth;
    logic              last;
  } led_word_t;

  typedef struct {
    logic [DATA_W-1:0] value;
    status_t           status;
    logic              last;
  } channel_result_t;

  // DUT ports
  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  start = 1'b0;
  logic                  busy;
  logic [2:0]            in_cmd = '0;
  logic [CH_W-1:0]       in_channel = '0;
  logic [DATA_W-1:0]     in_operand = '0;
  logic [1:0]            in_data_width = '0;
  logic                  in_last_of_pixel = 1'b0;
  logic                  out_valid;
  logic [DATA_W-1:0]     out_new_value;
  logic [1:0]            out_status;
  logic                  out_last_out;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DAT_W-1:0]  cfg_data = '0;

  // bench state
  led_word_t        words_to_send[$];
  channel_result_t  results_due[$];
  led_word_t        word_on_port;
  logic [DATA_W-1:0] store_model [TOTAL_CH];
  logic [1:0]       bank_width_model [4];
  int unsigned      idle_pct = 0;
  int unsigned      fail_count = 0;

  led_channel_modify_engine DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_cmd           (in_cmd),
    .in_channel       (in_channel),
    .in_operand       (in_operand),
    .in_data_width    (in_data_width),
    .in_last_of_pixel (in_last_of_pixel),
    .out_valid        (out_valid),
    .out_new_value    (out_new_value),
    .out_status       (out_status),
    .out_last_out     (out_last_out),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  always #6 clk = ~clk;

  function automatic logic [DATA_W-1:0] width_mask(logic [1:0] code);
    case (code)
      WCODE_8:  return 32'h0000_00FF;
      WCODE_16: return 32'h0000_FFFF;
      default:  return 32'hFFFF_FFFF;
    endcase
  endfunction

  // Read-modify-write of one channel at its bank's current element width.
  function automatic channel_result_t apply_channel_op(led_word_t w);
    channel_result_t   r;
    logic [1:0]        bw;
    logic [DATA_W-1:0] msk;
    logic [DATA_W-1:0] old;
    logic [DATA_W-1:0] d;
    logic [DATA_W:0]   sum;
    int unsigned       nbits;
    r.last   = w.last;
    r.value  = '0;
    r.status = ST_BAD_CHANNEL;
    if (w.channel >= TOTAL_CH) return r;
    bw    = bank_width_model[w.channel / CH_PER_BANK];
    msk   = width_mask(bw);
    nbits = (bw == WCODE_8) ? 8 : (bw == WCODE_16) ? 16 : 32;
    // stale wide values are cut to the current width
    old      = store_model[w.channel] & msk;
    r.value  = old;
    r.status = ST_OK;
    if (w.cmd == CMD_BAD) begin
      r.status = ST_BAD_OP;
    end else if (w.dwidth == WCODE_RSVD || bw == WCODE_RSVD || w.dwidth > bw) begin
      r.status = ST_TOO_WIDE;
    end else begin
      d = w.operand & width_mask(w.dwidth);
      case (cmd_t'(w.cmd))
        CMD_SET:     r.value = d;
        CMD_ADD:     r.value = (old + d) & msk;
        CMD_SUB:     r.value = (old - d) & msk;
        CMD_SHL:     r.value = (d >= nbits) ? '0 : ((old << d) & msk);
        CMD_SHR:     r.value = (d >= nbits) ? '0 : (old >> d);
        CMD_ADD_SAT: begin
          sum     = {1'b0, old} + {1'b0, d};
          r.value = (sum > {1'b0, msk}) ? msk : sum[DATA_W-1:0];
        end
        default:     r.value = (d > old) ? '0 : (old - d);
      endcase
      store_model[w.channel] = r.value;
    end
    return r;
  endfunction

  // Driver: predicts on acceptance, then puts up the next word or idles.
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) results_due.push_back(apply_channel_op(word_on_port));
      if (!start || !busy) begin
        if (words_to_send.size() != 0 && $urandom_range(99, 0) >= idle_pct) begin
          word_on_port     = words_to_send.pop_front();
          start            <= 1'b1;
          in_cmd           <= word_on_port.cmd;
          in_channel       <= word_on_port.channel;
          in_operand       <= word_on_port.operand;
          in_data_width    <= word_on_port.dwidth;
          in_last_of_pixel <= word_on_port.last;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor: each strobed result against the oldest prediction.
  always @(posedge clk) begin
    channel_result_t exp_r;
    if (rst_n && out_valid === 1'b1) begin
      if (results_due.size() == 0) begin
        $error("result with nothing expected: value %0h status %0d", out_new_value, out_status);
        fail_count++;
      end else begin
        exp_r = results_due.pop_front();
        if (out_new_value !== exp_r.value) begin
          $error("new_value: expected %0h, got %0h", exp_r.value, out_new_value);
          fail_count++;
        end
        if (out_status !== exp_r.status) begin
          $error("status: expected %0d, got %0d", exp_r.status, out_status);
          fail_count++;
        end
        if (out_last_out !== exp_r.last) begin
          $error("last_out: expected %0b, got %0b", exp_r.last, out_last_out);
          fail_count++;
        end
      end
    end
  end

  task automatic push_word(logic [2:0] cmd, int unsigned ch, logic [DATA_W-1:0] opnd,
                           logic [1:0] dw, logic last);
    led_word_t w;
    w.cmd     = cmd;
    w.channel = ch[CH_W-1:0];
    w.operand = opnd;
    w.dwidth  = dw;
    w.last    = last;
    words_to_send.push_back(w);
  endtask

  // Everything sent, every result back, engine not busy.
  task automatic wait_for_drain();
    do @(negedge clk);
    while (words_to_send.size() != 0 || start || busy !== 1'b0 || results_due.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_bank_widths(logic [1:0] w0, logic [1:0] w1, logic [1:0] w2,
                                   logic [1:0] w3);
    logic [1:0] codes [4];
    codes = '{w0, w1, w2, w3};
    for (int i = REG_BANK0_WIDTH; i <= REG_BANK3_WIDTH; i++) begin
      @(posedge clk);
      cfg_we    <= 1'b1;
      cfg_index <= i[CFG_IDX_W-1:0];
      cfg_data  <= codes[i];
      @(posedge clk);
      cfg_we <= 1'b0;
      bank_width_model[i] = codes[i];
    end
    @(negedge clk);
  endtask

  // Mostly well-formed words, biased to bank edges and repeated channels.
  task automatic push_random_word();
    int unsigned       ch;
    int unsigned       pick;
    logic [2:0]        cmd;
    logic [1:0]        dw;
    logic [1:0]        bw;
    logic [DATA_W-1:0] opnd;
    int unsigned       hot [9];
    hot  = '{0, 1, 143, 144, 287, 288, 431, 432, 575};
    pick = $urandom_range(99, 0);
    if (pick < 5)       ch = $urandom_range(1023, TOTAL_CH);
    else if (pick < 45) ch = hot[$urandom_range(8, 0)];
    else                ch = $urandom_range(TOTAL_CH - 1, 0);
    cmd = ($urandom_range(99, 0) < 5) ? CMD_BAD : 3'($urandom_range(CMD_SUB_SAT, CMD_SET));
    bw  = (ch < TOTAL_CH) ? bank_width_model[ch / CH_PER_BANK] : WCODE_32;
    if ($urandom_range(99, 0) < 12 || bw == WCODE_RSVD) dw = 2'($urandom_range(3, 0));
    else                                               dw = 2'($urandom_range(bw, 0));
    pick = $urandom_range(99, 0);
    if (pick < 10)      opnd = '0;
    else if (pick < 20) opnd = '1;
    else if (pick < 35) opnd = width_mask(dw) - $urandom_range(2, 0);
    else                opnd = $urandom;
    if ((cmd == CMD_SHL || cmd == CMD_SHR) && $urandom_range(99, 0) < 65)
      opnd = ($urandom & ~width_mask(dw)) | $urandom_range(40, 0);
    push_word(cmd, ch, opnd, dw, (ch % 3 == 2) ^ ($urandom_range(9, 0) == 0));
  endtask

  task automatic run_phase(logic [1:0] w0, logic [1:0] w1, logic [1:0] w2, logic [1:0] w3,
                           int unsigned pct, bit chunked);
    wait_for_drain();
    write_bank_widths(w0, w1, w2, w3);
    idle_pct = pct;
    // leftovers from the previous widths, read back through the new ones
    push_word(CMD_SUB_SAT, 431, '0, WCODE_8, 1'b0);
    push_word(CMD_ADD, 144, '0, WCODE_8, 1'b1);
    for (int n = 0; n < PHASE_WORDS; n++) begin
      push_random_word();
      // sender holds off until the engine has fully drained
      if (chunked && n % DRAIN_CHUNK == DRAIN_CHUNK - 1) wait_for_drain();
    end
  endtask

  initial begin
    foreach (store_model[i]) store_model[i] = '0;
    foreach (bank_width_model[i]) bank_width_model[i] = WCODE_8;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    wait_for_drain();

    // directed: one bank per width, reserved width on bank 3
    write_bank_widths(WCODE_8, WCODE_16, WCODE_32, WCODE_RSVD);
    push_word(CMD_SET,     0,   32'hFFFF_FFFF, WCODE_8,  1'b0);
    push_word(CMD_ADD,     0,   32'h0000_0001, WCODE_8,  1'b1);
    push_word(CMD_SUB,     0,   32'h0000_0001, WCODE_8,  1'b0);
    push_word(CMD_ADD_SAT, 0,   32'h0000_0005, WCODE_8,  1'b1);
    push_word(CMD_SUB_SAT, 0,   32'h0000_01FF, WCODE_8,  1'b0);
    push_word(CMD_SUB_SAT, 0,   32'h0000_0001, WCODE_8,  1'b1);
    push_word(CMD_SET,     143, 32'h0000_0081, WCODE_8,  1'b0);
    push_word(CMD_SHL,     143, 32'h0000_0001, WCODE_8,  1'b1);
    push_word(CMD_SHR,     143, 32'h0000_0008, WCODE_8,  1'b0);
    push_word(CMD_SET,     144, 32'hABCD_1234, WCODE_16, 1'b1);
    push_word(CMD_SET,     144, 32'h0000_0001, WCODE_32, 1'b0);
    push_word(CMD_SHL,     144, 32'hFFFF_000F, WCODE_16, 1'b1);
    push_word(CMD_SHR,     144, 32'h0000_0010, WCODE_16, 1'b0);
    push_word(CMD_SET,     431, 32'hFFFF_FFFF, WCODE_32, 1'b1);
    push_word(CMD_ADD_SAT, 431, 32'h0000_0001, WCODE_32, 1'b0);
    push_word(CMD_ADD,     431, 32'h0000_0001, WCODE_32, 1'b1);
    push_word(CMD_SUB,     431, 32'h0000_0001, WCODE_32, 1'b0);
    push_word(CMD_SHL,     431, 32'h0000_001F, WCODE_32, 1'b1);
    push_word(CMD_SET,     432, 32'h0000_0055, WCODE_8,  1'b0);
    push_word(CMD_SET,     575, 32'h0000_0055, WCODE_8,  1'b1);
    push_word(CMD_SET,     576, 32'h0000_0055, WCODE_8,  1'b0);
    push_word(CMD_BAD,     1023, '1,           WCODE_RSVD, 1'b1);
    push_word(CMD_BAD,     0,   32'h0000_0001, WCODE_RSVD, 1'b0);
    push_word(CMD_SET,     300, 32'h0000_0001, WCODE_RSVD, 1'b1);
    push_word(CMD_SET,     300, 32'h1234_5678, WCODE_32, 1'b0);

    run_phase(WCODE_8,    WCODE_16,   WCODE_32,   WCODE_RSVD, 0,  1'b0);
    run_phase(WCODE_32,   WCODE_32,   WCODE_32,   WCODE_32,   55, 1'b1);
    run_phase(WCODE_8,    WCODE_8,    WCODE_8,    WCODE_8,    16, 1'b0);
    run_phase(WCODE_16,   WCODE_RSVD, WCODE_RSVD, WCODE_32,   0,  1'b0);
    run_phase(WCODE_RSVD, WCODE_32,   WCODE_16,   WCODE_16,   55, 1'b0);

    wait_for_drain();
    repeat (10) @(negedge clk);
    if (results_due.size() != 0) begin
      $error("%0d results never arrived", results_due.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #RUN_LIMIT_NS;
    $display("== FAIL ==");
    $finish;
  end

endmodule

`default_nettype wire
